[rtl/vtd_pkg.sv]
package vtd_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Field widths of the item and result
  localparam int IDX_W   = 24;
  localparam int SLOT_W  = 10;
  localparam int TOTAL_W = 11;

  // One stored triple
  typedef struct packed {
    logic [IDX_W-1:0] position_index;
    logic [IDX_W-1:0] texcoord_index;
    logic [IDX_W-1:0] normal_index;
  } vtd_entry_t;

  localparam int ENTRY_W = $bits(vtd_entry_t);

  // Table memory request from the scan controller
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    vtd_entry_t        wr_data;
  } vtd_mem_req_t;

  // Finished lookup result
  typedef struct packed {
    logic [SLOT_W-1:0]  vertex_slot;
    logic               is_new;
    logic               overflow;
    logic [TOTAL_W-1:0] unique_total;
  } vtd_result_t;

endpackage

[rtl/vtd_if.sv]
interface vtd_in_if;
  import vtd_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] position_index;
  logic [IDX_W-1:0] texcoord_index;
  logic [IDX_W-1:0] normal_index;

  modport source (
    output valid, position_index, texcoord_index, normal_index,
    input  ready
  );

  modport sink (
    input  valid, position_index, texcoord_index, normal_index,
    output ready
  );
endinterface

interface vtd_out_if;
  import vtd_pkg::*;

  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  vertex_slot;
  logic               is_new;
  logic               overflow;
  logic [TOTAL_W-1:0] unique_total;

  modport source (
    output valid, vertex_slot, is_new, overflow, unique_total,
    input  ready
  );

  modport sink (
    input  valid, vertex_slot, is_new, overflow, unique_total,
    output ready
  );
endinterface

[rtl/vertex_triple_deduplicator_core.sv]
// Vertex triple deduplicator: each input transfer carries one face element
// (position, texcoord and normal index) and yields exactly one result with
// the table slot of that triple, a new-entry flag, an overflow flag and the
// running count of distinct triples. Distinct triples live in a synchronous
// table memory in order of first appearance and are compared one entry per
// cycle from slot 0 upward, so the scan for an item ends at its first matching
// slot or after the last stored entry, and with an empty table no scan takes
// place. The table's one read per cycle sets the pace of the scan. One item is
// worked on at a time, and the next transfer is taken in the cycle after the
// previous result has moved into the output register at the earliest. A
// finished result sits in the output register while the next item is taken
// and scanned. When the table is full and nothing matches, overflow is set,
// the slot reads 0 and the table is left unchanged. The table needs no
// clearing after reset: only entries below the count are ever compared.
module vertex_triple_deduplicator_core (
  input  logic             clk,
  input  logic             rst_n,
  vtd_in_if.sink           in_ch,
  vtd_out_if.source        out_ch
);
  import vtd_pkg::*;

  vtd_entry_t         in_entry;
  vtd_mem_req_t       mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               res_valid;
  logic               res_take;
  vtd_result_t        res;

  logic               out_valid_r;
  vtd_result_t        out_res_r;

  assign in_entry.position_index = in_ch.position_index;
  assign in_entry.texcoord_index = in_ch.texcoord_index;
  assign in_entry.normal_index   = in_ch.normal_index;

  vtd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_req.wr_en),
    .waddr (mem_req.wr_addr),
    .wdata (mem_req.wr_data),
    .re    (mem_req.rd_en),
    .raddr (mem_req.rd_addr),
    .rdata (mem_rdata)
  );

  vtd_scan_ctrl u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_entry  (in_entry),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // Output register: load when empty or being drained this cycle
  assign res_take = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vertex_slot  = out_res_r.vertex_slot;
  assign out_ch.is_new       = out_res_r.is_new;
  assign out_ch.overflow     = out_res_r.overflow;
  assign out_ch.unique_total = out_res_r.unique_total;

`ifndef NO_ASSERTIONS
  // Overflow result points at slot 0 and never appends
  a_overflow_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.overflow |-> res.vertex_slot == '0 && !res.is_new)
    else $error("overflow result with nonzero slot or append");

  // Table reads and the append write never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.wr_en && mem_req.rd_en))
    else $error("table read and write in the same cycle");

  // A taken result shows up in the output register next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_take |=> out_valid_r)
    else $error("taken result missing from output register");

  // No new item is taken while an append is being written
  a_no_accept_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> !in_ch.ready)
    else $error("input ready during table append");
`endif

endmodule

[rtl/vtd_ram.sv]
module vtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/vtd_scan_ctrl.sv]
module vtd_scan_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  vtd_pkg::vtd_entry_t    in_entry,
  output vtd_pkg::vtd_mem_req_t  mem_req,
  input  logic [vtd_pkg::ENTRY_W-1:0] mem_rdata,
  output logic                   res_valid,
  input  logic                   res_take,
  output vtd_pkg::vtd_result_t   res
);
  import vtd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  vtd_entry_t        key_r, key_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              found_r, found_nxt;
  logic [ADDR_W-1:0] slot_r, slot_nxt;

  logic hit;
  logic cmp_last;
  logic full;
  logic append;

  // Compare the entry read last cycle against the held key
  assign hit      = cmp_vld_r && (mem_rdata == key_r);
  assign cmp_last = cmp_vld_r && (cmp_idx_r == CNT_W'(count_r - 1'b1));
  assign full     = (count_r == CNT_W'(TABLE_DEPTH));
  assign append   = !found_r && !full;

  assign in_ready = (state_r == S_IDLE);

  // Table: one read per scan cycle while entries remain, append on take
  always_comb begin
    mem_req.rd_en   = (state_r == S_SCAN) && (iss_cnt_r < count_r);
    mem_req.rd_addr = iss_cnt_r[ADDR_W-1:0];
    mem_req.wr_en   = (state_r == S_DONE) && res_take && append;
    mem_req.wr_addr = count_r[ADDR_W-1:0];
    mem_req.wr_data = key_r;
  end

  // Result fields
  always_comb begin
    res_valid   = (state_r == S_DONE);
    res.is_new   = append;
    res.overflow = !found_r && full;
    if (found_r) begin
      res.vertex_slot = SLOT_W'(slot_r);
    end else if (full) begin
      res.vertex_slot = '0;
    end else begin
      res.vertex_slot = SLOT_W'(count_r);
    end
    res.unique_total = append ? TOTAL_W'(count_r + 1'b1) : TOTAL_W'(count_r);
  end

  // Next-state logic
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    key_nxt     = key_r;
    iss_cnt_nxt = iss_cnt_r;
    cmp_vld_nxt = cmp_vld_r;
    cmp_idx_nxt = cmp_idx_r;
    found_nxt   = found_r;
    slot_nxt    = slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt     = in_entry;
          iss_cnt_nxt = '0;
          cmp_vld_nxt = 1'b0;
          found_nxt   = 1'b0;
          state_nxt   = (count_r == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        // advance the read pointer while stored entries remain
        cmp_vld_nxt = mem_req.rd_en;
        cmp_idx_nxt = iss_cnt_r;
        if (mem_req.rd_en) begin
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        if (hit) begin
          found_nxt = 1'b1;
          slot_nxt  = cmp_idx_r[ADDR_W-1:0];
          state_nxt = S_DONE;
        end else if (cmp_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (res_take) begin
          if (append) begin
            count_nxt = count_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      cmp_vld_r <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      found_r   <= found_nxt;
    end
    key_r     <= key_nxt;
    iss_cnt_r <= iss_cnt_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    slot_r    <= slot_nxt;
  end

endmodule

[sim/tb_vertex_triple_deduplicator_core.sv]
`default_nettype none

module tb_vertex_triple_deduplicator_core;
  timeunit 1ns;
  timeprecision 1ps;

  import vtd_pkg::*;

  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          TAIL_CYCLES      = TABLE_DEPTH + 16;
  localparam int unsigned CYCLE_LIMIT      = 8_000_000;
  localparam int          SHOWN_MISMATCHES = 10;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  logic clk;
  logic rst_n;

  vtd_in_if  in_ch();
  vtd_out_if out_ch();

  vertex_triple_deduplicator_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the dedup table, in order of first appearance
  vtd_entry_t  seen_triples [TABLE_DEPTH];
  int          stored_count;
  vtd_result_t pending_results [$];

  int fault_count;
  bit quiet;         // no idling on either side
  bit hold_pending;  // ask the receiver for one long hold-off

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // Look up one triple: return the slot it lands in and update the shadow table
  function automatic vtd_result_t lookup_triple(input vtd_entry_t triple);
    vtd_result_t res;
    int          hit;
    hit = -1;
    for (int i = 0; i < stored_count && hit < 0; i++) begin
      if (seen_triples[i] == triple) hit = i;
    end
    res = '0;
    if (hit >= 0) begin
      res.vertex_slot = SLOT_W'(hit);
    end else if (stored_count < TABLE_DEPTH) begin
      seen_triples[stored_count] = triple;
      res.vertex_slot = SLOT_W'(stored_count);
      res.is_new      = 1'b1;
      stored_count++;
    end else begin
      res.overflow = 1'b1;
    end
    res.unique_total = TOTAL_W'(stored_count);
    return res;
  endfunction

  function automatic vtd_entry_t random_triple();
    vtd_entry_t t;
    t.position_index = IDX_W'($urandom);
    t.texcoord_index = IDX_W'($urandom);
    t.normal_index   = IDX_W'($urandom);
    return t;
  endfunction

  // Pick a stored triple, now and then from the first few slots for short scans
  function automatic vtd_entry_t stored_triple();
    int top;
    top = stored_count - 1;
    if ($urandom_range(0, 2) == 0 && top > 3) top = 3;
    return seen_triples[$urandom_range(0, top)];
  endfunction

  // Near miss of a stored triple: one bit flipped in one field
  function automatic vtd_entry_t flip_one_bit(input vtd_entry_t t);
    int b;
    b = $urandom_range(0, ENTRY_W - 1);
    t[b] = ~t[b];
    return t;
  endfunction

  // Offer one triple, hold it until the transfer, then predict its result
  task automatic send_triple(input vtd_entry_t triple);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.position_index <= triple.position_index;
    in_ch.texcoord_index <= triple.texcoord_index;
    in_ch.normal_index   <= triple.normal_index;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_results.push_back(lookup_triple(triple));
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_pending = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    vtd_result_t want;
    vtd_result_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.vertex_slot  = out_ch.vertex_slot;
      got.is_new       = out_ch.is_new;
      got.overflow     = out_ch.overflow;
      got.unique_total = out_ch.unique_total;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOWN_MISMATCHES)
          $display("unexpected result: slot %0d new %0b ovf %0b total %0d",
                   got.vertex_slot, got.is_new, got.overflow, got.unique_total);
      end else begin
        want = pending_results.pop_front();
        if (got.vertex_slot !== want.vertex_slot || got.is_new !== want.is_new ||
            got.overflow !== want.overflow || got.unique_total !== want.unique_total) begin
          fault_count++;
          if (fault_count <= SHOWN_MISMATCHES)
            $display("mismatch: expected slot %0d new %0b ovf %0b total %0d, got slot %0d new %0b ovf %0b total %0d",
                     want.vertex_slot, want.is_new, want.overflow, want.unique_total,
                     got.vertex_slot, got.is_new, got.overflow, got.unique_total);
        end
      end
    end
  end

  // Extremes of the fields, absent indices, one-field differences, repeats
  task automatic test_directed_triples();
    send_triple({IDX_W'(0), IDX_W'(0), IDX_W'(0)});
    send_triple({IDX_MAX, IDX_MAX, IDX_MAX});
    send_triple({IDX_W'(0), IDX_W'(0), IDX_W'(0)});
    send_triple({IDX_MAX, IDX_W'(0), IDX_W'(0)});
    send_triple({IDX_W'(0), IDX_MAX, IDX_W'(0)});
    send_triple({IDX_W'(0), IDX_W'(0), IDX_MAX});
    send_triple({IDX_W'(1), IDX_W'(2), IDX_W'(3)});
    send_triple({IDX_W'(1), IDX_W'(2), IDX_W'(3)});
    send_triple({IDX_W'(1), IDX_W'(2), IDX_W'(4)});
    send_triple({IDX_W'(1), IDX_W'(3), IDX_W'(3)});
    send_triple({IDX_W'(2), IDX_W'(2), IDX_W'(3)});
    send_triple({IDX_W'(3), IDX_W'(2), IDX_W'(1)});
    send_triple({IDX_MAX, IDX_MAX, IDX_MAX});
    send_triple({IDX_W'(0), IDX_MAX, IDX_W'(0)});
    send_triple({IDX_W'(2), IDX_W'(2), IDX_W'(3)});
  endtask

  // Long receiver hold-off while the sender keeps pushing, then a full drain
  task automatic test_output_backpressure();
    hold_pending = 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (i % 4 == 3) send_triple(random_triple());
      else            send_triple(seen_triples[i % 2]);
    end
    wait_results_drained();
  endtask

  // Random mix: repeats, fresh triples, near misses and small colliding indices
  task automatic test_random_mix(input int n_items);
    vtd_entry_t t;
    int         pick;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) wait_results_drained();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        t = stored_triple();
      end else if (pick < 75) begin
        t = random_triple();
      end else if (pick < 88) begin
        t = flip_one_bit(stored_triple());
      end else begin
        t.position_index = IDX_W'($urandom_range(0, 3));
        t.texcoord_index = IDX_W'($urandom_range(0, 3));
        t.normal_index   = IDX_W'($urandom_range(0, 3));
      end
      send_triple(t);
    end
  endtask

  // Append until the table is full, then probe misses and hits at the edges
  task automatic test_fill_and_overflow();
    while (stored_count < TABLE_DEPTH) send_triple(random_triple());
    send_triple(seen_triples[TABLE_DEPTH - 1]);
    send_triple(flip_one_bit(seen_triples[TABLE_DEPTH - 1]));
    send_triple(seen_triples[0]);
    send_triple({IDX_MAX, IDX_MAX, IDX_MAX - IDX_W'(1)});
    for (int i = 0; i < 16; i++) begin
      if ($urandom_range(0, 1) == 0) send_triple(stored_triple());
      else                           send_triple(random_triple());
    end
  endtask

  // Back-to-back traffic on a full table with no idling at all
  task automatic test_full_table_steady();
    quiet = 1'b1;
    for (int i = 0; i < 20; i++) begin
      case ($urandom_range(0, 2))
        0:       send_triple(stored_triple());
        1:       send_triple(flip_one_bit(stored_triple()));
        default: send_triple(seen_triples[$urandom_range(0, TABLE_DEPTH - 1)]);
      endcase
    end
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.position_index <= '0;
    in_ch.texcoord_index <= '0;
    in_ch.normal_index   <= '0;
    stored_count = 0;
    fault_count  = 0;
    quiet        = 1'b0;
    hold_pending = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_triples();
    test_output_backpressure();
    test_random_mix(560);
    test_fill_and_overflow();
    test_full_table_steady();

    // Let the last results out, then watch for stray transfers
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) fault_count++;

    if (fault_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
